// ===== rtl/txcw_pkg.sv =====
// ----------------------------------------------------------------------------
// txcw_pkg: shared types and constants of the text console writer
// Request and result words, request codes, special characters and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package txcw_pkg;

  // Request codes
  localparam logic [2:0] REQ_PUT   = 3'd0;
  localparam logic [2:0] REQ_CLEAR = 3'd1;
  localparam logic [2:0] REQ_GOTO  = 3'd2;
  localparam logic [2:0] REQ_ATTR  = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // Control characters and blank cell
  localparam logic [7:0] CH_BS        = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NL        = 8'd10;
  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] DEFAULT_ATTR = 8'h07;
  localparam int         TAB_STEP     = 4;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] char_code;
    logic [6:0] col_arg;
    logic [4:0] row_arg;
    logic [7:0] attr_value;
  } req_word_t;

  typedef struct packed {
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;
    logic       scrolled;
  } res_word_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_req;
    logic exec;
    logic bs_wr;
    logic rd_cap;
    logic copy;
    logic fill;
    logic clear;
    logic load_out;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_clear;
    logic is_read;
    logic is_bs;
    logic need_scroll;
    logic copy_end;
    logic fill_end;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/txcw_ram.sv =====
// ----------------------------------------------------------------------------
// txcw_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module txcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/txcw_datapath.sv =====
// ----------------------------------------------------------------------------
// txcw_datapath: cursor, attribute, screen store and result registers
// Executes the steps the controller commands: request decode and cursor
// update, backspace read-modify-write, cell read, scroll copy/fill, clear.
// ----------------------------------------------------------------------------
`default_nettype none

module txcw_datapath #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire txcw_pkg::dp_cmd_t   cmd,
  output txcw_pkg::dp_stat_t       stat,
  input  wire txcw_pkg::req_word_t req_word,
  output txcw_pkg::res_word_t      res_word
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int NCOPY = COLS * (ROWS - 1);

  txcw_pkg::req_word_t req_q;
  txcw_pkg::res_word_t res_q;
  logic [CW-1:0] x;
  logic [RW-1:0] y;
  logic [7:0]    attr;
  logic [AW-1:0] cnt;
  logic [7:0]    res_char;
  logic [7:0]    res_attr;
  logic          res_scr;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_data;

  // Request decode
  logic          is_put, is_read, put_nl, put_tab, put_bs, put_norm;
  logic          x_last, y_last, tab_wrap, wrap;
  logic [CW:0]   x_tab;
  logic [CW-1:0] col_sat, col_sel;
  logic [RW-1:0] row_sat, row_sel;
  logic [AW-1:0] addr_base;

  always_comb begin
    is_put   = (req_q.req_type == txcw_pkg::REQ_PUT);
    is_read  = (req_q.req_type == txcw_pkg::REQ_READ);
    put_nl   = is_put && (req_q.char_code == txcw_pkg::CH_NL);
    put_tab  = is_put && (req_q.char_code == txcw_pkg::CH_TAB);
    put_bs   = is_put && (req_q.char_code == txcw_pkg::CH_BS);
    put_norm = is_put && !put_nl && !put_tab && !put_bs;
    x_last   = (x == CW'(COLS - 1));
    y_last   = (y == RW'(ROWS - 1));
    x_tab    = {1'b0, x} + (CW+1)'(txcw_pkg::TAB_STEP);
    tab_wrap = (x_tab >= (CW+1)'(COLS));
    wrap     = put_nl || (put_tab && tab_wrap) || (put_norm && x_last);
    col_sat  = (int'(req_q.col_arg) >= COLS) ? CW'(COLS - 1) : CW'(req_q.col_arg);
    row_sat  = (int'(req_q.row_arg) >= ROWS) ? RW'(ROWS - 1) : RW'(req_q.row_arg);
    // Cell reads use the saturated arguments, everything else the cursor
    col_sel  = is_read ? col_sat : x;
    row_sel  = is_read ? row_sat : y;
    addr_base = AW'(row_sel * COLS) + AW'(col_sel);
  end

  always_comb begin
    stat.is_clear    = (req_q.req_type == txcw_pkg::REQ_CLEAR);
    stat.is_read     = is_read;
    stat.is_bs       = put_bs && (x != '0);
    stat.need_scroll = wrap && y_last;
    stat.copy_end    = (cnt == AW'(NCOPY));
    stat.fill_end    = (cnt == AW'(CELLS - 1));
  end

  // Screen store write port
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = {txcw_pkg::DEFAULT_ATTR, txcw_pkg::BLANK_CHAR};
    priority if (cmd.exec && put_norm) begin
      wr_en   = 1'b1;
      wr_addr = addr_base;
      wr_data = {attr, req_q.char_code};
    end else if (cmd.bs_wr) begin
      // keep the attribute, blank the character
      wr_en   = 1'b1;
      wr_addr = addr_base;
      wr_data = {rd_data[15:8], txcw_pkg::BLANK_CHAR};
    end else if (cmd.copy) begin
      // data read last cycle lands one row up
      wr_en   = (cnt != '0);
      wr_addr = cnt - AW'(1);
      wr_data = rd_data;
    end else if (cmd.fill) begin
      wr_en   = 1'b1;
      wr_data = {attr, txcw_pkg::BLANK_CHAR};
    end else if (cmd.clear) begin
      wr_en   = 1'b1;
    end
  end

  // Screen store read port
  always_comb begin
    rd_en   = (cmd.exec && (is_read || stat.is_bs)) || (cmd.copy && !stat.copy_end);
    rd_addr = cmd.copy ? (cnt + AW'(COLS)) : (is_read ? addr_base : addr_base - AW'(1));
  end

  txcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Cursor, attribute and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      x    <= '0;
      y    <= '0;
      attr <= txcw_pkg::DEFAULT_ATTR;
      cnt  <= '0;
    end else if (cmd.exec) begin
      cnt <= '0;
      unique case (req_q.req_type)
        txcw_pkg::REQ_PUT: begin
          if (wrap) begin
            x <= '0;
            if (!y_last) begin
              y <= y + RW'(1);
            end
          end else if (put_tab) begin
            x <= x_tab[CW-1:0];
          end else if (put_bs) begin
            if (x != '0) begin
              x <= x - CW'(1);
            end
          end else begin
            x <= x + CW'(1);
          end
        end
        txcw_pkg::REQ_CLEAR: begin
          x    <= '0;
          y    <= '0;
          attr <= txcw_pkg::DEFAULT_ATTR;
        end
        txcw_pkg::REQ_GOTO: begin
          x <= col_sat;
          y <= row_sat;
        end
        txcw_pkg::REQ_ATTR: begin
          attr <= req_q.attr_value;
        end
        default: begin
        end
      endcase
    end else if (cmd.copy) begin
      if (!stat.copy_end) begin
        cnt <= cnt + AW'(1);
      end
    end else if (cmd.fill || cmd.clear) begin
      cnt <= cnt + AW'(1);
    end
  end

  // Request and result payload
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req_word;
    end
    if (cmd.exec) begin
      res_char <= '0;
      res_attr <= '0;
      res_scr  <= stat.need_scroll;
    end
    if (cmd.rd_cap) begin
      res_char <= rd_data[7:0];
      res_attr <= rd_data[15:8];
    end
    if (cmd.load_out) begin
      res_q.cursor_col <= 7'(x);
      res_q.cursor_row <= 5'(y);
      res_q.cell_char  <= res_char;
      res_q.cell_attr  <= res_attr;
      res_q.scrolled   <= res_scr;
    end
  end

  assign res_word = res_q;

endmodule

`default_nettype wire

// ===== rtl/txcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// txcw_ctrl: sequencer of the text console writer
// Runs the reset clear pass, takes one request at a time, steps the
// datapath through it and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module txcw_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_stall,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output txcw_pkg::dp_cmd_t       cmd,
  input  wire txcw_pkg::dp_stat_t stat
);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_EXEC  = 9'b000000100,
    S_BSWR  = 9'b000001000,
    S_RDCAP = 9'b000010000,
    S_COPY  = 9'b000100000,
    S_FILL  = 9'b001000000,
    S_CLEAR = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_INIT: begin
        cmd.clear = 1'b1;
        if (stat.fill_end) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        priority if (stat.is_clear) begin
          state_next = S_CLEAR;
        end else if (stat.is_read) begin
          state_next = S_RDCAP;
        end else if (stat.is_bs) begin
          state_next = S_BSWR;
        end else if (stat.need_scroll) begin
          state_next = S_COPY;
        end else begin
          state_next = S_DONE;
        end
      end
      S_BSWR: begin
        cmd.bs_wr  = 1'b1;
        state_next = S_DONE;
      end
      S_RDCAP: begin
        cmd.rd_cap = 1'b1;
        state_next = S_DONE;
      end
      S_COPY: begin
        cmd.copy = 1'b1;
        if (stat.copy_end) begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        if (stat.fill_end) begin
          state_next = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.fill_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!res_valid || !res_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  assign req_stall = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer: character-cell text console
// Screen store of COLS x ROWS cells with cursor, attribute, wrap, scroll, clear.
// ----------------------------------------------------------------------------
// Usage:
//   Request words enter on req_valid/req_stall, one result word per request
//   leaves on res_valid/res_stall; a word moves when valid is high, stall low.
//   One request at a time. The result word is loaded into the output register
//   after the request step (after a store read step too for a cell read and
//   for a backspace away from column 0); the next request can be taken then.
//   A request that scrolls also copies ROWS-1 rows through the single store
//   port pair, then blanks the bottom row; a clear request blanks all
//   COLS*ROWS cells, one cell written per cycle.
//   After reset a clearing pass over the COLS*ROWS cells runs with req_stall
//   high; then the cursor is at 0,0 and the attribute is 0x07.
//   A stalled result holds in the output register; the next request is still
//   accepted and worked on up to the point where its result would be written.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire txcw_pkg::req_word_t req_word,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output txcw_pkg::res_word_t      res_word
);

  txcw_pkg::dp_cmd_t  cmd;
  txcw_pkg::dp_stat_t stat;

  txcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  txcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .req_word (req_word),
    .res_word (res_word)
  );

endmodule

`default_nettype wire

// ===== rtl/txcw_checker.sv =====
// ----------------------------------------------------------------------------
// txcw_checker: port-level checks of the text console writer
// Reset behavior, one request at a time, result hold, cursor bounds and scroll position.
// ----------------------------------------------------------------------------
`default_nettype none

module txcw_checker #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                req_valid,
  input wire logic                req_stall,
  input wire txcw_pkg::req_word_t req_word,
  input wire logic                res_valid,
  input wire logic                res_stall,
  input wire txcw_pkg::res_word_t res_word
);

  // Reset starts the clearing pass with no result pending
  a_reset: assert property (@(posedge clk) rst |=> (req_stall && !res_valid))
    else $error("requests or results open right after reset");

  // A request is worked on alone
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("second request accepted back to back");

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(res_word)))
    else $error("stalled result changed");

  // Cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((int'(res_word.cursor_col) < COLS) && (int'(res_word.cursor_row) < ROWS)))
    else $error("cursor off screen");

  // A scroll leaves the cursor at the start of the bottom row
  a_scroll_pos: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.scrolled) |->
      ((res_word.cursor_col == 7'd0) && (res_word.cursor_row == 5'(ROWS - 1))))
    else $error("scroll with cursor not at bottom row start");

endmodule

bind text_console_writer txcw_checker #(
  .COLS (COLS),
  .ROWS (ROWS)
) u_txcw_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_word  (req_word),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .res_word  (res_word)
);

`default_nettype wire
